// File: rtl/cpt_pkg.sv
// Package with shared types and codes for the counting prefix trie.
`default_nettype none
package cpt_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_EXACT  = 2'd2;
    localparam logic [1:0] CMD_PREFIX = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_SYM   = 3'd4;

    localparam logic REG_FIRST_CODE = 1'b0;
    localparam logic REG_ALPHABET   = 1'b1;

    localparam int STATUS_W = 3;
    localparam int OUT_COUNT_W = 32;
    localparam int OUT_NODE_W = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [OUT_COUNT_W-1:0] count_value;
        logic [OUT_NODE_W-1:0]  node_number;
        logic                   found;
    } t_result;
endpackage
`default_nettype wire

// File: rtl/cpt_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module cpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: rtl/cpt_sat.sv
// Shared saturating increment/decrement unit for the count updates.
`default_nettype none
module cpt_sat #(
    parameter int W = 32
) (
    input  wire logic         i_up,
    input  wire logic [W-1:0] i_value,
    output logic      [W-1:0] o_value
);
    always_comb begin
        if (i_up) begin
            o_value = (&i_value) ? i_value : i_value + W'(1);
        end else begin
            o_value = (i_value == '0) ? i_value : i_value - W'(1);
        end
    end
endmodule
`default_nettype wire

// File: rtl/counting_prefix_trie.sv
// Top level of the counting prefix trie: sequencer, node memories and stream ports.
`default_nettype none
// Counting prefix trie. Strings stream in one symbol per beat; the command comes from
// the first beat of a string, and the beat with is_last gives one result beat. A symbol
// beat passes through accept, child-link read and update; an empty beat that does not
// end the string is only accepted. The last beat then handles the exact count, walks
// the parent chain from the string's node to the root (insert and a successful erase
// only), each step reading and rewriting one subtree count through the shared saturating
// unit, and finally raises the result beat. The exact-count step also waits while the
// previous result beat has not been taken, and no beats are accepted while it waits.
// After reset a clearing pass sweeps the child-link memory (and the counts) before the
// first beat is taken.
// Input tdata: command[1:0], symbol[9:2], is_last[10], is_empty[11], zero fill.
module counting_prefix_trie #(
    parameter int NODE_CAPACITY = 1024,
    parameter int ALPHABET_MAX = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // command, symbol, is_last, is_empty
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // status, count_value, node_number, found
);
    import cpt_pkg::*;

    localparam int NW = $clog2(NODE_CAPACITY);
    localparam int AW = $clog2(ALPHABET_MAX);
    localparam int CW = NW + AW;
    localparam int CDEPTH = 1 << CW;
    localparam int UW = NW + 1;
    localparam int LW = $clog2(ALPHABET_MAX + 1) > 6 ? $clog2(ALPHABET_MAX + 1) : 6;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CWAIT  = 4'd2;
    localparam logic [3:0] S_CHILD  = 4'd3;
    localparam logic [3:0] S_EWAIT  = 4'd4;
    localparam logic [3:0] S_EXACT  = 4'd5;
    localparam logic [3:0] S_SWAIT  = 4'd6;
    localparam logic [3:0] S_SUB    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]    r_state;
    logic [7:0]    r_first_code;
    logic [5:0]    r_alpha;
    logic [CW:0]   r_clr;
    logic [UW-1:0] r_used;
    logic [NW-1:0] r_cursor;
    logic          r_missing;
    logic [2:0]    r_err;
    logic [1:0]    r_cmd;
    logic          r_in_str;
    logic [AW-1:0] r_sym;
    logic          r_last;
    logic          r_up;
    logic [NW-1:0] r_walk;
    logic [NW:0]   r_steps;
    t_result       r_res;
    logic          r_out_v;
    t_result       n_res;
    logic          exact_walk;

    // Memories.
    logic              c_we;
    logic [CW-1:0]     c_addr;
    logic [NW:0]       c_wd, c_rd;
    logic              p_we;
    logic [NW-1:0]     p_addr, p_wd, p_rd;
    logic              e_we, t_we;
    logic [NW-1:0]     e_addr, t_addr;
    logic [COUNT_WIDTH-1:0] e_wd, e_rd, t_wd, t_rd, sat_in, sat_out;

    cpt_ram #(.WIDTH(NW + 1), .DEPTH(CDEPTH)) u_child (
        .i_clk, .i_we(c_we), .i_addr(c_addr), .i_wdata(c_wd), .o_rdata(c_rd));
    cpt_ram #(.WIDTH(NW), .DEPTH(NODE_CAPACITY)) u_parent (
        .i_clk, .i_we(p_we), .i_addr(p_addr), .i_wdata(p_wd), .o_rdata(p_rd));
    cpt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NODE_CAPACITY)) u_exact (
        .i_clk, .i_we(e_we), .i_addr(e_addr), .i_wdata(e_wd), .o_rdata(e_rd));
    cpt_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NODE_CAPACITY)) u_sub (
        .i_clk, .i_we(t_we), .i_addr(t_addr), .i_wdata(t_wd), .o_rdata(t_rd));
    cpt_sat #(.W(COUNT_WIDTH)) u_sat (.i_up(r_up), .i_value(sat_in), .o_value(sat_out));

    logic [1:0] in_cmd;
    logic [7:0] in_sym;
    logic       in_last, in_empty, in_take;
    logic [LW-1:0] lim;
    logic [8:0] off;
    logic       sym_bad, sym_go;
    logic       s_hs, m_hs;

    assign in_cmd   = s_axis_tdata[1:0];
    assign in_sym   = s_axis_tdata[9:2];
    assign in_last  = s_axis_tdata[10];
    assign in_empty = s_axis_tdata[11];
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_hs = s_axis_tvalid && s_axis_tready;
    assign m_hs = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {2'b0, r_res.found, r_res.node_number, r_res.count_value,
                           r_res.status};

    assign in_take = !in_empty && (r_in_str ? (r_err == ST_OK && !r_missing) : 1'b1);
    assign lim = (LW'(r_alpha) > LW'(ALPHABET_MAX)) ? LW'(ALPHABET_MAX) : LW'(r_alpha);
    assign off = {1'b0, in_sym} - {1'b0, r_first_code};
    // The borrow bit marks a code below the first code.
    assign sym_bad = off[8] || ({1'b0, off[7:0]} >= 9'(lim));
    assign sym_go = in_take && !sym_bad;

    logic [NW-1:0] cur_start;
    assign cur_start = r_in_str ? r_cursor : '0;
    assign sat_in = (r_state == S_EXACT) ? e_rd : t_rd;

    always_comb begin
        c_we = 1'b0; c_addr = {r_cursor, r_sym}; c_wd = '0;
        p_we = 1'b0; p_addr = r_walk; p_wd = r_cursor;
        e_we = 1'b0; e_addr = r_cursor; e_wd = sat_out;
        t_we = 1'b0; t_addr = r_walk; t_wd = sat_out;
        case (r_state)
            S_CLEAR: begin
                c_we = 1'b1; c_addr = r_clr[CW-1:0];
                e_we = 1'b1; e_addr = r_clr[NW-1:0]; e_wd = '0;
                t_we = 1'b1; t_addr = r_clr[NW-1:0]; t_wd = '0;
            end
            S_IDLE: begin
                c_addr = {cur_start, off[AW-1:0]};
            end
            S_CHILD: begin
                if (!c_rd[NW] && r_cmd == CMD_INSERT && r_used < UW'(NODE_CAPACITY)) begin
                    c_we = 1'b1; c_wd = {1'b1, r_used[NW-1:0]};
                    p_we = 1'b1; p_addr = r_used[NW-1:0];
                end
            end
            S_EWAIT: begin
                // A prefix query reads the subtree count of the string's node.
                t_addr = r_cursor;
            end
            S_EXACT: begin
                e_we = (r_err == ST_OK) && ((r_cmd == CMD_INSERT) ||
                       (r_cmd == CMD_ERASE && !r_missing && e_rd != '0));
            end
            S_SUB: begin
                t_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_res = '0;
        exact_walk = 1'b0;
        if (r_err != ST_OK) begin
            n_res.status = r_err;
        end else if (r_cmd == CMD_INSERT) begin
            n_res.node_number = OUT_NODE_W'(r_cursor);
            n_res.found = 1'b1;
            exact_walk = 1'b1;
        end else if (r_cmd == CMD_ERASE) begin
            if (r_missing) begin
                n_res.status = ST_NOT_FOUND;
            end else if (e_rd == '0) begin
                n_res.status = ST_ZERO;
                n_res.found = 1'b1;
            end else begin
                n_res.found = 1'b1;
                exact_walk = 1'b1;
            end
        end else if (!r_missing) begin
            n_res.found = 1'b1;
            n_res.count_value = OUT_COUNT_W'(r_cmd == CMD_EXACT ? e_rd : t_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_first_code <= 8'd97; r_alpha <= 6'd26;
            r_clr <= '0; r_used <= UW'(1); r_cursor <= '0; r_missing <= 1'b0;
            r_err <= ST_OK; r_cmd <= CMD_INSERT; r_in_str <= 1'b0; r_out_v <= 1'b0;
            r_last <= 1'b0; r_up <= 1'b0; r_walk <= '0; r_steps <= '0; r_sym <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIRST_CODE) r_first_code <= i_cfg_wdata;
                else r_alpha <= i_cfg_wdata[5:0];
            end
            if (m_hs) r_out_v <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (CW+1)'(CDEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_hs) begin
                    if (!r_in_str) begin
                        r_cmd <= in_cmd; r_missing <= 1'b0;
                        r_cursor <= '0; r_in_str <= 1'b1;
                    end
                    if (in_take && sym_bad) r_err <= ST_BAD_SYM;
                    else if (!r_in_str) r_err <= ST_OK;
                    r_last <= in_last;
                    r_sym <= off[AW-1:0];
                    if (sym_go) begin
                        r_state <= S_CWAIT;
                    end else if (in_last) begin
                        r_state <= S_EWAIT;
                    end
                end
                S_CWAIT: r_state <= S_CHILD;
                S_CHILD: begin
                    if (c_rd[NW]) begin
                        r_cursor <= c_rd[NW-1:0];
                    end else if (r_cmd != CMD_INSERT) begin
                        r_missing <= 1'b1;
                    end else if (r_used >= UW'(NODE_CAPACITY)) begin
                        r_err <= ST_FULL;
                    end else begin
                        r_cursor <= r_used[NW-1:0];
                        r_used <= r_used + 1'b1;
                    end
                    r_state <= r_last ? S_EWAIT : S_IDLE;
                end
                S_EWAIT: begin
                    r_in_str <= 1'b0;
                    r_up <= (r_cmd == CMD_INSERT);
                    // The result register is reused only once its beat has gone out.
                    if (!r_out_v || m_hs) r_state <= S_EXACT;
                end
                S_EXACT: begin
                    r_res <= n_res;
                    r_walk <= r_cursor; r_steps <= '0;
                    r_state <= exact_walk ? S_SWAIT : S_OUT;
                end
                S_SWAIT: r_state <= S_SUB;
                S_SUB: begin
                    r_walk <= p_rd; r_steps <= r_steps + 1'b1;
                    if (r_walk == '0 || r_steps >= (NW+1)'(NODE_CAPACITY)) r_state <= S_OUT;
                    else r_state <= S_SWAIT;
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(NODE_CAPACITY)) else $error("node count overflow");
    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> r_last) else $error("result without last beat");
`endif
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the counting prefix trie, with its own trie predictor.
`default_nettype none
module tb;
    import cpt_pkg::*;

    localparam int NODES      = 1024;
    localparam int ALPHA      = 32;
    localparam int STALL_MAX  = 200000;
    localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] sym;
        logic       last;
        logic       empty;
        logic       typed;
        t_result    res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    counting_prefix_trie uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Trie mirror.
    logic        kid_ok [NODES*ALPHA] = '{default: 1'b0};
    logic [9:0]  kid_of [NODES*ALPHA] = '{default: '0};
    logic [9:0]  up_of [NODES] = '{default: '0};
    logic [31:0] exact_cnt [NODES] = '{default: '0};
    logic [31:0] below_cnt [NODES] = '{default: '0};
    int          nodes_taken = 1;
    logic [9:0]  walk_node = '0;
    logic        walk_lost = 1'b0;
    logic [2:0]  walk_err = ST_OK;
    logic [1:0]  walk_cmd = CMD_INSERT;
    logic        mid_string = 1'b0;
    logic [7:0]  base_code;
    logic [5:0]  alpha_n;

    t_result     pending_results[$];
    logic        row_typed;
    t_result     row_res;
    logic        idle_on;
    int          bad_cnt = 0;
    int          stall_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic walk_counts(input logic [9:0] start, input logic grow);
        logic [9:0] n;
        int steps;
        n = start;
        steps = 0;
        forever begin
            if (grow) begin
                if (below_cnt[n] != CNT_TOP) below_cnt[n] = below_cnt[n] + 1;
            end else if (below_cnt[n] != 0) begin
                below_cnt[n] = below_cnt[n] - 1;
            end
            if (n == 0 || steps >= NODES) break;
            n = up_of[n];
            steps++;
        end
    endtask

    task automatic follow_symbol(input logic [7:0] sym);
        int lim;
        int k;
        int slot;
        lim = (alpha_n > ALPHA) ? ALPHA : alpha_n;
        if (sym < base_code || int'(sym) - int'(base_code) >= lim) begin
            walk_err = ST_BAD_SYM;
            return;
        end
        k = int'(sym) - int'(base_code);
        slot = int'(walk_node) * ALPHA + k;
        if (kid_ok[slot]) begin
            walk_node = kid_of[slot];
        end else if (walk_cmd != CMD_INSERT) begin
            walk_lost = 1'b1;
        end else if (nodes_taken >= NODES) begin
            walk_err = ST_FULL;
        end else begin
            kid_ok[slot] = 1'b1;
            kid_of[slot] = nodes_taken[9:0];
            up_of[nodes_taken] = walk_node;
            walk_node = nodes_taken[9:0];
            nodes_taken++;
        end
    endtask

    // Advances the mirror by one beat; returns 1 when the beat ends a string.
    task automatic trie_beat(input logic [1:0] cmd, input logic [7:0] sym,
                             input logic last, input logic empty,
                             output logic done, output t_result r);
        r = '0;
        done = 1'b0;
        if (!mid_string) begin
            walk_cmd = cmd;
            walk_node = '0;
            walk_lost = 1'b0;
            walk_err = ST_OK;
            mid_string = 1'b1;
        end
        if (!empty && walk_err == ST_OK && !walk_lost) follow_symbol(sym);
        if (!last) return;
        done = 1'b1;
        mid_string = 1'b0;
        if (walk_err != ST_OK) begin
            r.status = walk_err;
        end else if (walk_cmd == CMD_INSERT) begin
            if (exact_cnt[walk_node] != CNT_TOP) exact_cnt[walk_node] += 1;
            walk_counts(walk_node, 1'b1);
            r.node_number = walk_node;
            r.found = 1'b1;
        end else if (walk_cmd == CMD_ERASE) begin
            if (walk_lost) begin
                r.status = ST_NOT_FOUND;
            end else if (exact_cnt[walk_node] == 0) begin
                r.status = ST_ZERO;
                r.found = 1'b1;
            end else begin
                exact_cnt[walk_node] -= 1;
                walk_counts(walk_node, 1'b0);
                r.found = 1'b1;
            end
        end else if (!walk_lost) begin
            r.count_value = (walk_cmd == CMD_EXACT) ? exact_cnt[walk_node]
                                                    : below_cnt[walk_node];
            r.found = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        logic done;
        logic moved;
        t_result r;
        t_result got;
        t_result want;
        if (i_rst_n) begin
            moved = 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                got.status      = m_axis_tdata[2:0];
                got.count_value = m_axis_tdata[34:3];
                got.node_number = m_axis_tdata[44:35];
                got.found       = m_axis_tdata[45];
                if (pending_results.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10) $display("unexpected result beat %h", m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("mismatch: exp st=%0d cnt=%0d node=%0d f=%0d,",
                                     want.status, want.count_value, want.node_number,
                                     want.found,
                                     " got st=%0d cnt=%0d node=%0d f=%0d",
                                     got.status, got.count_value, got.node_number,
                                     got.found);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                trie_beat(s_axis_tdata[1:0], s_axis_tdata[9:2], s_axis_tdata[10],
                          s_axis_tdata[11], done, r);
                if (done) pending_results = {pending_results, row_typed ? row_res : r};
            end
            stall_cnt <= moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk)
        m_axis_tready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;

    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] sym,
                             input logic last, input logic empty,
                             input logic typed, input t_result res);
        while (idle_on && $urandom_range(99) < 35) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, empty, last, sym, cmd};
        row_typed = typed;
        row_res = res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == REG_FIRST_CODE) base_code = val;
        else alpha_n = val[5:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_string(input int max_len, input int ins_pct, input int bad_pct);
        logic [1:0] cmd;
        int len;
        int lim;
        logic empty;
        logic [7:0] sym;
        lim = (alpha_n > ALPHA) ? ALPHA : alpha_n;
        if ($urandom_range(99) < ins_pct) cmd = CMD_INSERT;
        else cmd = 2'($urandom_range(3));
        len = $urandom_range(max_len, 1);
        for (int i = 0; i < len; i++) begin
            empty = ($urandom_range(99) < 8);
            if ($urandom_range(99) < bad_pct) sym = 8'($urandom);
            else sym = 8'(int'(base_code) + $urandom_range(lim - 1));
            // Later beats carry a random command, which the block must ignore.
            send_beat((i == 0) ? cmd : 2'($urandom), sym, i == len - 1, empty, 1'b0, '0);
        end
    endtask

    t_row dir_rows[$];

    function automatic t_row mk(input logic [1:0] c, input logic [7:0] s, input logic l,
                                input logic e, input logic t, input logic [2:0] st,
                                input logic [31:0] cn, input logic [9:0] nd,
                                input logic f);
        t_row row;
        row.cmd = c; row.sym = s; row.last = l; row.empty = e; row.typed = t;
        row.res.status = st; row.res.count_value = cn;
        row.res.node_number = nd; row.res.found = f;
        return row;
    endfunction

    initial begin
        base_code = 8'd97;
        alpha_n = 6'd26;
        row_typed = 1'b0;
        row_res = '0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_FIRST_CODE;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = {dir_rows, mk(CMD_EXACT,  8'd0,   1, 1, 1, ST_OK,        0, 0, 1)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  8'd0,   1, 1, 1, ST_ZERO,      0, 0, 1)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "a",    1, 0, 1, ST_NOT_FOUND, 0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_INSERT, "a",    1, 0, 1, ST_OK,        0, 1, 1)};
        dir_rows = {dir_rows, mk(CMD_PREFIX, 8'd0,   1, 1, 1, ST_OK,        1, 0, 1)};
        dir_rows = {dir_rows, mk(CMD_INSERT, "z",    1, 0, 1, ST_OK,        0, 2, 1)};
        dir_rows = {dir_rows, mk(CMD_INSERT, 8'd123, 1, 0, 1, ST_BAD_SYM,   0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_INSERT, 8'd96,  1, 0, 1, ST_BAD_SYM,   0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_INSERT, 8'd255, 1, 0, 1, ST_BAD_SYM,   0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_EXACT,  "b",    1, 0, 1, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_INSERT, "a",    0, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_PREFIX, "b",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_PREFIX, 8'd0,   0, 1, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "a",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_EXACT,  "a",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "a",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "a",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_INSERT, 8'hFF,  1, 1, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "a",    0, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_ERASE,  "b",    1, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_EXACT,  "z",    0, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_EXACT,  8'd96,  0, 0, 0, ST_OK,        0, 0, 0)};
        dir_rows = {dir_rows, mk(CMD_EXACT,  "a",    1, 0, 0, ST_OK,        0, 0, 0)};
        foreach (dir_rows[i])
            send_beat(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].last,
                      dir_rows[i].empty, dir_rows[i].typed, dir_rows[i].res);

        // Narrow and extreme alphabets first, then a long insert-heavy run to fill the table.
        write_reg(REG_FIRST_CODE, 8'd0);
        write_reg(REG_ALPHABET, 8'd1);
        repeat (10) random_string(4, 40, 7);
        write_reg(REG_FIRST_CODE, 8'd255);
        write_reg(REG_ALPHABET, 8'd32);
        repeat (10) random_string(3, 40, 7);
        write_reg(REG_FIRST_CODE, 8'd48);
        write_reg(REG_ALPHABET, 8'd3);
        idle_on = 1'b0;
        repeat (30) random_string(4, 40, 7);
        idle_on = 1'b1;
        write_reg(REG_FIRST_CODE, 8'd97);
        write_reg(REG_ALPHABET, 8'd26);
        repeat (10) random_string(3, 40, 7);
        drain();
        write_reg(REG_ALPHABET, 8'd32);
        while (nodes_taken < NODES) random_string(20, 100, 0);
        repeat (15) random_string(6, 50, 7);

        drain();
        if (bad_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
rtl/cpt_pkg.sv
rtl/cpt_ram.sv
rtl/cpt_sat.sv
rtl/counting_prefix_trie.sv
verif/tb.sv
